>>> hdl/fit_policy_region_allocator_assert.svh
// Assertion macros used by the allocator top level.
`ifndef FIT_POLICY_REGION_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_REGION_ALLOCATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FPRA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define FPRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

>>> hdl/fpra_pkg.sv
// Package with types, sizes and codes of the region allocator.
`timescale 1ns / 1ps
package fpra_pkg;

  localparam int FREE_ENTRIES  = 16;
  localparam int OWNER_ENTRIES = 16;
  localparam int ADDR_BITS     = 16;
  localparam int FIDX_BITS     = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int OIDX_BITS     = (OWNER_ENTRIES > 1) ? $clog2(OWNER_ENTRIES) : 1;
  localparam int FCNT_BITS     = $clog2(FREE_ENTRIES + 1);
  localparam int OCNT_BITS     = $clog2(OWNER_ENTRIES + 1);
  localparam int FREE_W        = 2 * ADDR_BITS;
  localparam int OWNER_W       = 16 + 2 * ADDR_BITS;
  localparam logic [15:0] MEM_SIZE_RESET = 16'd1024;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_FIT     = 3'd1,
    ST_ID_UNKNOWN = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_ZERO_SIZE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_SPARE = 2'd3
  } fit_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic {
    REG_MEM_SIZE = 1'b0,
    REG_FIT      = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OSCAN,
    S_OWAIT,
    S_FSCAN,
    S_FLAST,
    S_DECIDE,
    S_RDA,
    S_RDB,
    S_UPD,
    S_DONE
  } state_t;

endpackage

>>> hdl/fpra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fpra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/fit_policy_region_allocator.sv
// Top level of the region allocator: handshakes, control sequencer and tables.
`timescale 1ns / 1ps
//
//  Channel     | Signals                           | Direction | Content
//  ------------+-----------------------------------+-----------+---------------------------
//  request     | s_axis_tvalid/tready/tdata/tuser  | in        | tuser req_type; tdata size, id
//  result      | m_axis_tvalid/tready/tdata        | out       | status, id, start, size
//  config      | cfg_valid/ready/index/data        | in        | memory_size, fit_policy
//
// A result is valid after its item has been through the walks and the steps that follow:
// the owner table and then the free table are walked one entry per cycle through the
// single read port of their RAM, each walk drains its read pipeline in a wait state
// (S_OWAIT, S_FLAST), then a decision, a reread of the above neighbor and the write-back
// follow. A zero-size allocate skips the walks and later steps and goes to the result.
// The result sits in an output register; a new request is taken only after the previous
// result has left, so a stalled output stalls the input side. Reset (and a memory_size
// write) clears the valid bits but that of free entry zero, which is rewritten on the
// spot and kept valid unless the new size is zero.
module fit_policy_region_allocator
  import fpra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] req_size, [31:16] owner_id
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [2:0] status, [18:3] granted_id,
                                      // [34:19] region_start, [50:35] region_size, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  `include "fit_policy_region_allocator_assert.svh"

  typedef logic [ADDR_BITS-1:0] addr_t;

  // Configuration. The memory size itself lives in free entry zero.
  fit_t        fit_policy;
  logic [15:0] next_id;

  // Valid bits kept in flip-flops; payloads live in RAMs.
  logic [FREE_ENTRIES-1:0]  fvalid;
  logic [OWNER_ENTRIES-1:0] ovalid;

  // RAM ports.
  logic                 f_we;
  logic [FIDX_BITS-1:0] f_waddr, f_raddr;
  logic [FREE_W-1:0]    f_wdata, f_rdata;
  logic                 o_we;
  logic [OIDX_BITS-1:0] o_waddr, o_raddr;
  logic [OWNER_W-1:0]   o_wdata, o_rdata;

  fpra_ram #(.WIDTH(FREE_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  fpra_ram #(.WIDTH(OWNER_W), .DEPTH(OWNER_ENTRIES)) u_owner_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  // Request registers.
  state_t      state, state_next;
  req_t        rq_type;
  logic [15:0] rq_size, rq_id, rq_gid;

  // Scan counters, one address issued per cycle, data in the next cycle.
  logic [OCNT_BITS-1:0] ocnt;
  logic [FCNT_BITS-1:0] fcnt;
  logic [OIDX_BITS-1:0] o_prev;
  logic [FIDX_BITS-1:0] f_prev;
  logic                 o_pv, f_pv;

  // Scan results.
  logic                 o_hit;
  logic [OIDX_BITS-1:0] o_sel;
  addr_t                own_s, own_l;
  logic                 o_free_hit;
  logic [OIDX_BITS-1:0] o_free;
  logic                 b_hit, a_hit, e_hit;
  logic [FIDX_BITS-1:0] b_idx, a_idx, e_idx;
  addr_t                a_len;
  logic                 best_hit;
  logic [FIDX_BITS-1:0] best_idx;
  addr_t                best_s, best_l;

  // Result register.
  status_t     r_status;
  logic [15:0] r_id, r_start, r_size;

  assign m_axis_tdata = {5'd0, r_size, r_start, r_id, r_status};
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign cfg_ready     = (state == S_IDLE) && !m_axis_tvalid;

  wire in_fire  = s_axis_tvalid && s_axis_tready;
  wire cfg_fire = cfg_valid && cfg_ready;

  addr_t fr_s, fr_l, fr_e, ow_e;
  assign fr_s = f_rdata[ADDR_BITS-1:0];
  assign fr_l = f_rdata[FREE_W-1:ADDR_BITS];
  assign fr_e = addr_t'(fr_s + fr_l);
  assign ow_e = addr_t'(own_s + own_l);

  // Candidate comparison for the allocation scan.
  logic take;
  always_comb begin
    take = 1'b0;
    if (!best_hit) begin
      take = 1'b1;
    end else begin
      case (fit_policy)
        FIT_BEST:  take = (fr_l < best_l) || (fr_l == best_l && fr_s < best_s);
        FIT_WORST: take = (fr_l > best_l) || (fr_l == best_l && fr_s < best_s);
        default:   take = fr_s < best_s;
      endcase
    end
  end

  // Next state and RAM addressing.
  always_comb begin
    state_next = state;
    f_raddr    = fcnt[FIDX_BITS-1:0];
    o_raddr    = ocnt[OIDX_BITS-1:0];
    case (state)
      S_IDLE: if (in_fire) begin
        if (s_axis_tuser == REQ_ALLOC && s_axis_tdata[15:0] == 16'd0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_OSCAN;
        end
      end
      S_OSCAN: if (ocnt == OCNT_BITS'(OWNER_ENTRIES - 1)) begin
        state_next = S_OWAIT;
      end
      S_OWAIT: state_next = S_FSCAN;
      S_FSCAN: if (fcnt == FCNT_BITS'(FREE_ENTRIES - 1)) begin
        state_next = S_FLAST;
      end
      S_FLAST: state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = S_RDA;
        f_raddr = (rq_type == REQ_ALLOC) ? best_idx : a_idx;
      end
      S_RDA: state_next = S_UPD;
      S_UPD: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Write ports.
  always_comb begin
    f_we = 1'b0; f_waddr = '0; f_wdata = '0;
    o_we = 1'b0; o_waddr = o_free; o_wdata = {addr_t'(rq_size), addr_t'(0), rq_gid};
    if (rst || (cfg_fire && cfg_index == REG_MEM_SIZE)) begin
      f_we = 1'b1;
      f_wdata = {addr_t'(rst ? MEM_SIZE_RESET : cfg_data), addr_t'(0)};
    end else if (state == S_UPD && r_status == ST_OK) begin
      f_we = 1'b1;
      if (rq_type == REQ_ALLOC) begin
        f_waddr = best_idx;
        f_wdata = {addr_t'(best_l - addr_t'(rq_size)), best_s};
        o_we = 1'b1;
        o_wdata = {addr_t'(rq_size), addr_t'(best_s + best_l - addr_t'(rq_size)), rq_gid};
      end else if (b_hit) begin
        // Below neighbor grows by the region and by the above one if present.
        f_waddr = b_idx;
        f_wdata = {addr_t'(best_l + own_l + (a_hit ? a_len : addr_t'(0))), best_s};
      end else if (a_hit) begin
        f_waddr = a_idx;
        f_wdata = {addr_t'(own_l + a_len), own_s};
      end else begin
        f_waddr = e_idx;
        f_wdata = {own_l, own_s};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fit_policy <= FIT_FIRST;
      next_id <= 16'd1;
      fvalid <= FREE_ENTRIES'(1);
      ovalid <= '0;
      m_axis_tvalid <= 1'b0;
      ocnt <= '0; fcnt <= '0;
      o_pv <= 1'b0; f_pv <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_fire) begin
        if (cfg_index == REG_MEM_SIZE) begin
          fvalid <= FREE_ENTRIES'(cfg_data != 16'd0);
          ovalid <= '0;
        end else begin
          fit_policy <= fit_t'(cfg_data[1:0]);
        end
      end
      o_pv <= (state == S_OSCAN);
      f_pv <= (state == S_FSCAN);
      o_prev <= ocnt[OIDX_BITS-1:0];
      f_prev <= fcnt[FIDX_BITS-1:0];
      if (state == S_OSCAN) ocnt <= ocnt + 1'b1;
      if (state == S_FSCAN) fcnt <= fcnt + 1'b1;
      case (state)
        S_IDLE: if (in_fire) begin
          rq_type <= req_t'(s_axis_tuser);
          rq_size <= s_axis_tdata[15:0];
          rq_id <= s_axis_tdata[31:16];
          rq_gid <= (s_axis_tuser == REQ_ALLOC) ? next_id : s_axis_tdata[31:16];
          if (s_axis_tuser == REQ_ALLOC) next_id <= next_id + 16'd1;
          ocnt <= '0; fcnt <= '0;
          o_hit <= 1'b0; o_free_hit <= 1'b0;
          b_hit <= 1'b0; a_hit <= 1'b0; e_hit <= 1'b0; best_hit <= 1'b0;
          r_id <= (s_axis_tuser == REQ_ALLOC) ? next_id : s_axis_tdata[31:16];
          r_status <= ST_ZERO_SIZE;
          r_start <= '0; r_size <= '0;
        end
        S_DECIDE: begin
          if (rq_type == REQ_ALLOC) begin
            if (!o_free_hit) r_status <= ST_TABLE_FULL;
            else if (!best_hit) r_status <= ST_NO_FIT;
            else begin
              r_status <= ST_OK;
              r_start <= 16'(best_s + best_l - addr_t'(rq_size));
              r_size <= rq_size;
            end
          end else begin
            if (!o_hit) r_status <= ST_ID_UNKNOWN;
            else if (!b_hit && !a_hit && !e_hit) r_status <= ST_TABLE_FULL;
            else begin
              r_status <= ST_OK;
              r_start <= 16'(own_s);
              r_size <= 16'(own_l);
            end
          end
        end
        // The above neighbor was addressed in S_DECIDE; its length is on the read
        // port now and is needed by the write-back in S_UPD.
        S_RDA: a_len <= fr_l;
        S_UPD: begin
          if (r_status == ST_OK) begin
            if (rq_type == REQ_ALLOC) begin
              ovalid[o_free] <= 1'b1;
              if (best_l == addr_t'(rq_size)) fvalid[best_idx] <= 1'b0;
            end else begin
              ovalid[o_sel] <= 1'b0;
              if (b_hit && a_hit) fvalid[a_idx] <= 1'b0;
              else if (!b_hit && !a_hit) fvalid[e_idx] <= 1'b1;
            end
          end
        end
        S_DONE: m_axis_tvalid <= 1'b1;
        default: ;
      endcase
      // Owner scan data.
      if (o_pv) begin
        if (!ovalid[o_prev] && !o_free_hit) begin
          o_free_hit <= 1'b1; o_free <= o_prev;
        end
        if (ovalid[o_prev] && !o_hit && o_rdata[15:0] == rq_id) begin
          o_hit <= 1'b1; o_sel <= o_prev;
          own_s <= o_rdata[16 +: ADDR_BITS];
          own_l <= o_rdata[16 + ADDR_BITS +: ADDR_BITS];
        end
      end
      // Free scan data.
      if (f_pv) begin
        if (!fvalid[f_prev]) begin
          if (!e_hit) begin e_hit <= 1'b1; e_idx <= f_prev; end
        end else if (rq_type == REQ_ALLOC) begin
          if (fr_l >= addr_t'(rq_size) && take) begin
            best_hit <= 1'b1; best_idx <= f_prev; best_s <= fr_s; best_l <= fr_l;
          end
        end else if (!b_hit && fr_e == own_s) begin
          b_hit <= 1'b1; b_idx <= f_prev; best_s <= fr_s; best_l <= fr_l;
        end else if (!a_hit && fr_s == ow_e) begin
          a_hit <= 1'b1; a_idx <= f_prev;
        end
      end
    end
  end

  `FPRA_ASSERT_NEXT(a_in_done, in_fire, !s_axis_tready)
  `FPRA_ASSERT_IMPL(a_no_cfg_busy, state != S_IDLE, !cfg_ready)
  `FPRA_ASSERT_NEXT(a_done_valid, state == S_DONE, m_axis_tvalid)
  `FPRA_ASSERT_IMPL(a_ok_size, m_axis_tvalid && r_status == ST_OK && rq_type == REQ_ALLOC,
                    r_size != 16'd0)

endmodule
